FILE: rtl/assert_macros.svh
// assert_macros.svh
// concurrent assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/ttf_pkg.sv
// ttf_pkg.sv
// shared widths, status codes, divider handshake types and saturation helper
// no dependencies
package ttf_pkg;

   localparam int CoordW = 32;
   localparam int DiffW  = CoordW + 1;
   localparam int ProdW  = 2 * DiffW;
   localparam int AccW   = ProdW + 1;
   localparam int MagW   = AccW - 16;
   localparam int QuotW  = 33;
   localparam int RemW   = AccW + 32;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_UVDEG = 2'd1;
   localparam logic [1:0] STAT_DROP  = 2'd2;

   localparam logic [31:0] DET_THRESHOLD_RESET = 32'd429;

   typedef struct packed {
      logic                   start;
      logic signed [AccW-1:0] num;
      logic signed [AccW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [CoordW-1:0] quot;
   } div_rsp_type;

   // clamp a magnitude with sign to signed 32 bits
   function automatic logic [CoordW-1:0] sat_q16(input logic neg, input logic [MagW-1:0] mag);
      logic [MagW-1:0] lim;
      logic [MagW-1:0] m;
      lim = neg ? MagW'(33'h0_8000_0000) : MagW'(33'h0_7FFF_FFFF);
      m   = (mag > lim) ? lim : mag;
      return neg ? CoordW'(-m) : CoordW'(m);
   endfunction

endpackage

FILE: rtl/ttf_divider.sv
// ttf_divider.sv
// restoring divider, one quotient bit per cycle, num * 2^16 / den saturated
// depends on ttf_pkg
module ttf_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  ttf_pkg::div_req_type div_req,
   output ttf_pkg::div_rsp_type div_rsp
);
   import ttf_pkg::*;

   logic [RemW-1:0]  rem_ff, rem_in;
   logic [RemW-1:0]  ds_ff, ds_in;
   logic [QuotW-1:0] q_ff, q_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             neg_ff, neg_in;
   logic [AccW-1:0]  num_abs, den_abs;
   logic             ge;

   assign num_abs = div_req.num[AccW-1] ? AccW'(-div_req.num) : AccW'(div_req.num);
   assign den_abs = div_req.den[AccW-1] ? AccW'(-div_req.den) : AccW'(div_req.den);
   assign ge      = rem_ff >= ds_ff;

   // one compare and subtract per cycle
   always_comb begin
      rem_in  = rem_ff;
      ds_in   = ds_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = {16'b0, num_abs, 16'b0};
         ds_in   = {den_abs, 32'b0};
         q_in    = '0;
         cnt_in  = 6'(QuotW - 1);
         busy_in = 1'b1;
         neg_in  = div_req.num[AccW-1] ^ div_req.den[AccW-1];
      end else if (busy_ff) begin
         rem_in = ge ? rem_ff - ds_ff : rem_ff;
         ds_in  = ds_ff >> 1;
         q_in   = {q_ff[QuotW-2:0], ge};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      ds_ff  <= ds_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = sat_q16(neg_ff, MagW'(q_ff));

endmodule

FILE: rtl/triangle_tangent_frame.sv
// Triangle tangent frame. Corners arrive one beat each; slots 0 and 1 are stored,
// slot 3 is dropped, slot 2 completes the triangle and yields one result beat.
// For a full triangle one shared 33x33 multiplier works through twenty products
// in pairs, and each of the six tangent and bitangent terms passes through the
// one-bit-per-cycle divider after its product pair. A uv-degenerate triangle
// finishes after the normal, and a triangle with coincident corners finishes
// without any products. The input is not ready while a triangle is being worked
// on. csr_data sets the uv determinant threshold.
module triangle_tangent_frame (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, tex_u, tex_v
   input  logic [159:0] req_tdata,
   // corner_slot
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // normal_x/y/z, tangent_x/y/z, bitangent_x/y/z
   output logic [287:0] rsp_tdata,
   // tri_status
   output logic [1:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data
);
   import ttf_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_ACC  = 6'b000100,
      ST_WB   = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   localparam logic [3:0] PairDet  = 4'd0;
   localparam logic [3:0] PairNz   = 4'd3;
   localparam logic [3:0] PairLast = 4'd9;

   state_type state_ff, state_in;
   logic [3:0] pair_ff, pair_in;
   logic       half_ff, half_in;
   logic       degen_ff, degen_in;
   logic [31:0] thr_ff;
   logic [31:0] held_pos_ff [6];
   logic [31:0] held_uv_ff [4];
   logic signed [DiffW-1:0] e1_ff [3];
   logic signed [DiffW-1:0] e2_ff [3];
   logic signed [DiffW-1:0] s1_ff, s2_ff, t1_ff, t2_ff;
   logic signed [ProdW-1:0] prod_ff;
   logic signed [AccW-1:0]  acc_ff, det_ff;
   logic [31:0] res_ff [9];
   logic [1:0]  status_ff, status_in;
   logic        rsp_valid_ff;
   logic [287:0] rsp_data_ff;
   logic [1:0]   rsp_user_ff;

   logic signed [DiffW-1:0] opa, opb;
   logic        req_fire, out_free;
   logic [31:0] in_pos [3];
   logic [31:0] in_u, in_v;
   logic        eq01, eq12, eq02;
   logic [AccW-1:0] acc_abs;
   logic [3:0]  res_idx;
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign in_pos[0] = req_tdata[31:0];
   assign in_pos[1] = req_tdata[63:32];
   assign in_pos[2] = req_tdata[95:64];
   assign in_u      = req_tdata[127:96];
   assign in_v      = req_tdata[159:128];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   assign eq01 = held_pos_ff[0] == held_pos_ff[3] && held_pos_ff[1] == held_pos_ff[4] &&
                 held_pos_ff[2] == held_pos_ff[5];
   assign eq12 = held_pos_ff[3] == in_pos[0] && held_pos_ff[4] == in_pos[1] &&
                 held_pos_ff[5] == in_pos[2];
   assign eq02 = held_pos_ff[0] == in_pos[0] && held_pos_ff[1] == in_pos[1] &&
                 held_pos_ff[2] == in_pos[2];

   assign acc_abs = acc_ff[AccW-1] ? AccW'(-acc_ff) : AccW'(acc_ff);
   assign res_idx = pair_ff - 4'd1;

   // operand selection for the shared multiplier
   always_comb begin
      case (pair_ff)
         4'd0: begin opa = half_ff ? s2_ff : s1_ff;       opb = half_ff ? t1_ff : t2_ff;       end
         4'd1: begin opa = half_ff ? e1_ff[2] : e1_ff[1]; opb = half_ff ? e2_ff[1] : e2_ff[2]; end
         4'd2: begin opa = half_ff ? e1_ff[0] : e1_ff[2]; opb = half_ff ? e2_ff[2] : e2_ff[0]; end
         4'd3: begin opa = half_ff ? e1_ff[1] : e1_ff[0]; opb = half_ff ? e2_ff[0] : e2_ff[1]; end
         4'd4: begin opa = half_ff ? t1_ff : t2_ff; opb = half_ff ? e2_ff[0] : e1_ff[0]; end
         4'd5: begin opa = half_ff ? t1_ff : t2_ff; opb = half_ff ? e2_ff[1] : e1_ff[1]; end
         4'd6: begin opa = half_ff ? t1_ff : t2_ff; opb = half_ff ? e2_ff[2] : e1_ff[2]; end
         4'd7: begin opa = half_ff ? s2_ff : s1_ff; opb = half_ff ? e1_ff[0] : e2_ff[0]; end
         4'd8: begin opa = half_ff ? s2_ff : s1_ff; opb = half_ff ? e1_ff[1] : e2_ff[1]; end
         4'd9: begin opa = half_ff ? s2_ff : s1_ff; opb = half_ff ? e1_ff[2] : e2_ff[2]; end
         default: begin opa = '0; opb = '0; end
      endcase
   end

   // divider launch on a tangent or bitangent numerator
   assign div_req.start = (state_ff == ST_WB) && (pair_ff > PairNz);
   assign div_req.num   = acc_ff;
   assign div_req.den   = det_ff;

   ttf_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // sequencer
   always_comb begin
      state_in  = state_ff;
      pair_in   = pair_ff;
      half_in   = half_ff;
      degen_in  = degen_ff;
      status_in = status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_tuser == 2'd2) begin
               pair_in  = PairDet;
               half_in  = 1'b0;
               degen_in = 1'b0;
               if (eq01 || eq12 || eq02) begin
                  status_in = STAT_DROP;
                  state_in  = ST_DONE;
               end else begin
                  status_in = STAT_OK;
                  state_in  = ST_MUL;
               end
            end
         end
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            half_in  = !half_ff;
            state_in = half_ff ? ST_WB : ST_MUL;
         end
         ST_WB: begin
            if (pair_ff == PairDet) begin
               if (acc_abs <= AccW'(thr_ff)) begin
                  degen_in  = 1'b1;
                  status_in = STAT_UVDEG;
               end
               pair_in  = pair_ff + 4'd1;
               state_in = ST_MUL;
            end else if (pair_ff <= PairNz) begin
               if (pair_ff == PairNz && degen_ff) begin
                  state_in = ST_DONE;
               end else begin
                  pair_in  = pair_ff + 4'd1;
                  state_in = ST_MUL;
               end
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (pair_ff == PairLast) begin
                  state_in = ST_DONE;
               end else begin
                  pair_in  = pair_ff + 4'd1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pair_ff      <= PairDet;
         half_ff      <= 1'b0;
         degen_ff     <= 1'b0;
         status_ff    <= STAT_OK;
         thr_ff       <= DET_THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pair_ff   <= pair_in;
         half_ff   <= half_in;
         degen_ff  <= degen_in;
         status_ff <= status_in;
         if (csr_valid && csr_ready) thr_ff <= csr_data;
         if (state_ff == ST_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // corner store and edge differences
   always_ff @(posedge clock) begin
      if (req_fire && req_tuser == 2'd0) begin
         held_pos_ff[0] <= in_pos[0];
         held_pos_ff[1] <= in_pos[1];
         held_pos_ff[2] <= in_pos[2];
         held_uv_ff[0]  <= in_u;
         held_uv_ff[1]  <= in_v;
      end
      if (req_fire && req_tuser == 2'd1) begin
         held_pos_ff[3] <= in_pos[0];
         held_pos_ff[4] <= in_pos[1];
         held_pos_ff[5] <= in_pos[2];
         held_uv_ff[2]  <= in_u;
         held_uv_ff[3]  <= in_v;
      end
      if (req_fire && req_tuser == 2'd2) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= {held_pos_ff[i+3][31], held_pos_ff[i+3]} -
                        {held_pos_ff[i][31], held_pos_ff[i]};
            e2_ff[i] <= {in_pos[i][31], in_pos[i]} - {held_pos_ff[i][31], held_pos_ff[i]};
            res_ff[i]   <= '0;
            res_ff[i+3] <= '0;
            res_ff[i+6] <= '0;
         end
         s1_ff <= {held_uv_ff[2][31], held_uv_ff[2]} - {held_uv_ff[0][31], held_uv_ff[0]};
         s2_ff <= {in_u[31], in_u} - {held_uv_ff[0][31], held_uv_ff[0]};
         t1_ff <= {held_uv_ff[3][31], held_uv_ff[3]} - {held_uv_ff[1][31], held_uv_ff[1]};
         t2_ff <= {in_v[31], in_v} - {held_uv_ff[1][31], held_uv_ff[1]};
      end
      // multiply, then accumulate the difference of two products
      if (state_ff == ST_MUL) prod_ff <= opa * opb;
      if (state_ff == ST_ACC) begin
         acc_ff <= half_ff ? acc_ff - {prod_ff[ProdW-1], prod_ff} : {prod_ff[ProdW-1], prod_ff};
      end
      // write back
      if (state_ff == ST_WB && pair_ff == PairDet) det_ff <= acc_ff;
      if (state_ff == ST_WB && pair_ff != PairDet && pair_ff <= PairNz) begin
         res_ff[res_idx] <= sat_q16(acc_ff[AccW-1], acc_abs[AccW-1:16]);
      end
      if (state_ff == ST_DIV && div_rsp.done) res_ff[res_idx] <= div_rsp.quot;
      // output register
      if (state_ff == ST_DONE && out_free) begin
         rsp_data_ff <= {res_ff[8], res_ff[7], res_ff[6], res_ff[5], res_ff[4],
                         res_ff[3], res_ff[2], res_ff[1], res_ff[0]};
         rsp_user_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

FILE: rtl/ttf_checker.sv
// ttf_checker.sv
// port-level checks on the tangent frame block, bound to the top level
// depends on ttf_pkg and assert_macros.svh
`include "assert_macros.svh"

module ttf_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [159:0] req_tdata,
   input logic [1:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [287:0] rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic         csr_valid,
   input logic         csr_ready,
   input logic [31:0]  csr_data
);
   import ttf_pkg::*;

   // a stalled result beat stays and holds its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   // a completing corner blocks the input while the triangle is worked on
   `ASSERT_NEXT(a_busy, clock, reset, req_tvalid && req_tready && req_tuser == 2'd2, !req_tready)
   // a dropped triangle carries no geometry
   `ASSERT_IMPLIES(a_drop_zero, clock, reset, rsp_tvalid && rsp_tuser == STAT_DROP, rsp_tdata == '0)
   // uv degenerate keeps tangent and bitangent at zero
   `ASSERT_IMPLIES(a_uvdeg_zero, clock, reset, rsp_tvalid && rsp_tuser == STAT_UVDEG, rsp_tdata[287:96] == '0)

endmodule

bind triangle_tangent_frame ttf_checker u_checker (.*);
